[rtl/core/rbb_pkg.sv]
// Shared types, constants and helper functions of the rectangle blit engine.
package rbb_pkg;

    localparam int MAX_SIDE    = 4096;
    localparam int CNT_W       = 12;
    localparam int SIDE_W      = 13;
    localparam int POS_W       = 13;
    localparam int OFFSET_W    = 30;
    localparam int PIXEL_W     = 32;
    localparam int BCNT_W      = 3;
    localparam int BETA_W      = 15;
    localparam int PITCH_W     = 16;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [BETA_W-1:0] BETA_MAX = 15'h7f80;
    localparam logic [7:0]        ALPHA_ON = 8'hff;

    localparam logic [2:0] FMT_Y8       = 3'd0;
    localparam logic [2:0] FMT_R5G6B5   = 3'd1;
    localparam logic [2:0] FMT_A8R8G8B8 = 3'd2;
    localparam logic [2:0] FMT_X8       = 3'd3;
    localparam logic [2:0] FMT_X8_Z8    = 3'd4;

    localparam logic MODE_COPY  = 1'b0;
    localparam logic MODE_BLEND = 1'b1;

    localparam logic [2:0] REG_FORMAT = 3'd0;
    localparam logic [2:0] REG_MODE   = 3'd1;
    localparam logic [2:0] REG_BETA   = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_ORG_X  = 3'd4;
    localparam logic [2:0] REG_ORG_Y  = 3'd5;
    localparam logic [2:0] REG_WIDTH  = 3'd6;
    localparam logic [2:0] REG_HEIGHT = 3'd7;

    typedef struct packed {
        logic [2:0]         pix_fmt;
        logic               blit_mode;
        logic [BETA_W-1:0]  beta_factor;
        logic [PITCH_W-1:0] row_pitch;
        logic [CNT_W-1:0]   origin_x;
        logic [CNT_W-1:0]   origin_y;
        logic [SIDE_W-1:0]  rect_width;
        logic [SIDE_W-1:0]  rect_height;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] src;
        logic [PIXEL_W-1:0] dst;
        logic [POS_W-1:0]   row_abs;
        logic [POS_W-1:0]   col_abs;
        logic               last;
    } entry_t;

    function automatic logic [SIDE_W-1:0] side_len(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        begin
            if (v == '0)
                r = SIDE_W'(1);
            else if (v > SIDE_W'(MAX_SIDE))
                r = SIDE_W'(MAX_SIDE);
            else
                r = v;
            return r;
        end
    endfunction

    function automatic logic [BCNT_W-1:0] pixel_bytes(input logic [2:0] fmt,
                                                      input logic mode);
        logic [BCNT_W-1:0] r;
        begin
            if (mode == MODE_BLEND)
                r = BCNT_W'(4);
            else if (fmt == FMT_Y8)
                r = BCNT_W'(1);
            else if (fmt == FMT_R5G6B5)
                r = BCNT_W'(2);
            else
                r = BCNT_W'(4);
            return r;
        end
    endfunction

endpackage

[rtl/core/rect_blit_copy_or_beta_blend.sv]
// Top level of the rectangle blit pixel engine with copy or beta blend.
// An accepted request passes through the request queue, the product stage registers and the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the one-request-per-cycle back pipeline.
// A two-entry queue absorbs up to two requests while the output is stalled.
// Reset clears the position counters and the pipeline; registers take their defaults.
module rect_blit_copy_or_beta_blend
    import rbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // src_pixel[31:0], dst_pixel[63:32]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [71:0]       m_axis_tdata,   // wr_offset, pixel_out, byte_count, zero pad
    output logic              m_axis_tlast
);

    cfg_t                cfg;
    logic                push;
    entry_t              push_entry;
    logic                q_full;
    logic                q_not_empty;
    entry_t              q_head;
    logic                pop;
    logic [OFFSET_W-1:0] wr_offset;
    logic [PIXEL_W-1:0]  pixel_out;
    logic [BCNT_W-1:0]   byte_count;

    rbb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .q_full     (q_full),
        .src_pixel  (s_axis_tdata[31:0]),
        .dst_pixel  (s_axis_tdata[63:32]),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    rbb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    rbb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .wr_offset   (wr_offset),
        .pixel_out   (pixel_out),
        .byte_count  (byte_count),
        .last_pixel  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, byte_count, pixel_out, wr_offset};

endmodule

[rtl/core/rbb_cfg.sv]
// Configuration register file with an APB-style write and read port.
module rbb_cfg
    import rbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pix_fmt      <= FMT_A8R8G8B8;
            cfg_reg.blit_mode    <= MODE_COPY;
            cfg_reg.beta_factor  <= '0;
            cfg_reg.row_pitch    <= '0;
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.rect_width   <= SIDE_W'(1);
            cfg_reg.rect_height  <= SIDE_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FORMAT: cfg_reg.pix_fmt      <= pwdata[2:0];
                REG_MODE:   cfg_reg.blit_mode    <= pwdata[0];
                REG_BETA:   cfg_reg.beta_factor  <= pwdata[BETA_W-1:0];
                REG_PITCH:  cfg_reg.row_pitch    <= pwdata[PITCH_W-1:0];
                REG_ORG_X:  cfg_reg.origin_x     <= pwdata[CNT_W-1:0];
                REG_ORG_Y:  cfg_reg.origin_y     <= pwdata[CNT_W-1:0];
                REG_WIDTH:  cfg_reg.rect_width   <= pwdata[SIDE_W-1:0];
                REG_HEIGHT: cfg_reg.rect_height  <= pwdata[SIDE_W-1:0];
                default:    cfg_reg.pix_fmt      <= cfg_reg.pix_fmt;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FORMAT: prdata = DATA_W'(cfg_reg.pix_fmt);
            REG_MODE:   prdata = DATA_W'(cfg_reg.blit_mode);
            REG_BETA:   prdata = DATA_W'(cfg_reg.beta_factor);
            REG_PITCH:  prdata = DATA_W'(cfg_reg.row_pitch);
            REG_ORG_X:  prdata = DATA_W'(cfg_reg.origin_x);
            REG_ORG_Y:  prdata = DATA_W'(cfg_reg.origin_y);
            REG_WIDTH:  prdata = DATA_W'(cfg_reg.rect_width);
            REG_HEIGHT: prdata = DATA_W'(cfg_reg.rect_height);
            default:    prdata = '0;
        endcase
    end

endmodule

[rtl/core/rbb_front.sv]
// Front end: accepts pixel requests and tags them with their rectangle position.
module rbb_front
    import rbb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    input  logic   q_full,
    input  logic [PIXEL_W-1:0] src_pixel,
    input  logic [PIXEL_W-1:0] dst_pixel,
    output logic   in_ready,
    output logic   push,
    output entry_t push_entry
);

    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [SIDE_W-1:0] col_inc;
    logic [SIDE_W-1:0] row_inc;
    logic              col_end;
    logic              row_end;

    assign in_ready = ~q_full;
    assign push     = in_valid & ~q_full;

    always_comb
    begin
        w       = side_len(cfg.rect_width);
        h       = side_len(cfg.rect_height);
        col_inc = {1'b0, col_reg} + SIDE_W'(1);
        row_inc = {1'b0, row_reg} + SIDE_W'(1);
        col_end = col_inc >= w;
        row_end = row_inc >= h;

        push_entry.src     = src_pixel;
        push_entry.dst     = dst_pixel;
        push_entry.row_abs = {1'b0, cfg.origin_y} + {1'b0, row_reg};
        push_entry.col_abs = {1'b0, cfg.origin_x} + {1'b0, col_reg};
        push_entry.last    = col_end & row_end;

        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/core/rbb_queue.sv]
// Two-entry request queue between the front and back ends.
module rbb_queue
    import rbb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t head
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

[rtl/core/rbb_back.sv]
// Back end: product stage and blend/offset stage feeding the output register.
module rbb_back
    import rbb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   q_not_empty,
    input  entry_t q_head,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output logic [OFFSET_W-1:0] wr_offset,
    output logic [PIXEL_W-1:0]  pixel_out,
    output logic [BCNT_W-1:0]   byte_count,
    output logic                last_pixel
);

    logic                 adv;
    logic [BETA_W-1:0]    beta;
    logic [BETA_W-1:0]    inv;
    logic [BCNT_W-1:0]    stride;
    logic [PIXEL_W-1:0]   copy_pix;
    logic [POS_W+1:0]     col_off;

    logic                 v1_reg;
    logic [22:0]          ps_reg [3];
    logic [22:0]          pd_reg [3];
    logic [28:0]          row_prod_reg;
    logic [POS_W+1:0]     col_off_reg;
    logic [PIXEL_W-1:0]   copy_pix_reg;
    logic [7:0]           dst_alpha_reg;
    logic                 last1_reg;

    logic                 v2_reg;
    logic [OFFSET_W-1:0]  off_reg, off_next;
    logic [PIXEL_W-1:0]   pix_reg, pix_next;
    logic                 last2_reg;

    logic [23:0]          sum [3];
    logic [15:0]          quo [3];
    logic [16:0]          est [3];

    assign adv         = ~v2_reg | out_ready;
    assign pop         = adv & q_not_empty;
    assign out_valid   = v2_reg;
    assign wr_offset   = off_reg;
    assign pixel_out   = pix_reg;
    assign byte_count  = stride;
    assign last_pixel  = last2_reg;

    always_comb
    begin
        beta   = (cfg.beta_factor > BETA_MAX) ? BETA_MAX : cfg.beta_factor;
        inv    = BETA_MAX - beta;
        stride = pixel_bytes(cfg.pix_fmt, cfg.blit_mode);
        case (stride)
            BCNT_W'(1): copy_pix = {24'd0, q_head.src[7:0]};
            BCNT_W'(2): copy_pix = {16'd0, q_head.src[15:0]};
            default:    copy_pix = q_head.src;
        endcase
        case (stride)
            BCNT_W'(1): col_off = {2'd0, q_head.col_abs};
            BCNT_W'(2): col_off = {1'b0, q_head.col_abs, 1'b0};
            default:    col_off = {q_head.col_abs, 2'd0};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ps_reg[c] <= {15'd0, q_head.src[8*c +: 8]} * {8'd0, beta};
                pd_reg[c] <= {15'd0, q_head.dst[8*c +: 8]} * {8'd0, inv};
            end
            row_prod_reg  <= {16'd0, q_head.row_abs} * {13'd0, cfg.row_pitch};
            col_off_reg   <= col_off;
            copy_pix_reg  <= copy_pix;
            dst_alpha_reg <= q_head.dst[31:24];
            last1_reg     <= q_head.last;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum[c] = {1'b0, ps_reg[c]} + {1'b0, pd_reg[c]};
            quo[c] = sum[c][22:7];
            est[c] = {1'b0, quo[c]} + 17'(quo[c][15:8]) + 17'd1;
        end
        if (cfg.blit_mode == MODE_BLEND)
            pix_next = {dst_alpha_reg, est[2][15:8], est[1][15:8], est[0][15:8]};
        else
            pix_next = copy_pix_reg;
        if (cfg.pix_fmt == FMT_X8)
            pix_next[31:24] = ALPHA_ON;
        else if (cfg.pix_fmt == FMT_X8_Z8)
            pix_next[31:24] = '0;
        off_next = OFFSET_W'({1'b0, row_prod_reg} + 30'(col_off_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off_reg   <= off_next;
            pix_reg   <= pix_next;
            last2_reg <= last1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= q_not_empty;
            v2_reg <= v1_reg;
        end
    end

endmodule
